// ===== hw/rtl/lts_pkg.sv =====
// shared types and constants for the lottery ticket scheduler
package lts_pkg;

	localparam int MaxEntries = 16;
	localparam int IdBits = 8;
	localparam int QueueDepth = 2;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READY = 2'd2;
	localparam logic [1:0] ACT_DRAW = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_PRESENT = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NO_TICKETS = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] thread_id;
		logic [7:0] ticket_count;
		logic ready_flag;
		logic [30:0] random_value;
	} cmd_t;

endpackage

// ===== hw/rtl/lottery_ticket_scheduler_core.sv =====
// top level of the lottery ticket scheduler
// One command is processed at a time by the table engine; a two-entry queue in front
// keeps taking commands while it works, until it is full. Insert and set-ready make a scan
// of the table, and remove a scan and, when the entry is found, a shift of the later entries;
// a draw makes a ticket-sum pass and, if any tickets are ready, 31 restoring-division steps
// for the modulo and a walk over the entries. The single result register is released by
// the output transfer before the next command starts. No clearing pass is needed after reset.
module lottery_ticket_scheduler_core
	import lts_pkg::*;
#(
	parameter int MAX_ENTRIES = MaxEntries,
	parameter int ID_BITS = IdBits
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [7:0] thread_id,
	input logic [7:0] ticket_count,
	input logic ready_flag,
	input logic [30:0] random_value,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [7:0] winner_id,
	output logic [4:0] occupancy
);

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_take;

	assign in_cmd = '{action: action, thread_id: thread_id, ticket_count: ticket_count,
		ready_flag: ready_flag, random_value: random_value};

	lts_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
	);

	lts_back #(.MAX_ENTRIES(MAX_ENTRIES), .ID_BITS(ID_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_stall(out_stall), .out_status(status),
		.out_winner(winner_id), .out_occ(occupancy)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= 5'(MAX_ENTRIES)) else $error("occupancy over table size");

	a_winner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> winner_id == '0) else $error("winner on failure");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NO_TICKETS) else $error("bad status code");

endmodule

// ===== hw/rtl/lts_front.sv =====
// input stage and command queue between the handshake and the table engine
module lts_front
	import lts_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cmd_t in_cmd,
	output logic q_valid,
	input logic q_take,
	output cmd_t q_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_take;
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/lts_back.sv =====
// table engine: lookup, insert, remove, ready update and lottery draw
module lts_back
	import lts_pkg::*;
#(
	parameter int MAX_ENTRIES = MaxEntries,
	parameter int ID_BITS = IdBits
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input cmd_t q_cmd,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] out_status,
	output logic [7:0] out_winner,
	output logic [4:0] out_occ
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int TW = 8 + CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [ID_BITS-1:0] ids_q [MAX_ENTRIES];
	logic [7:0] tix_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] rdy_q;
	logic [CW-1:0] count_q;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [CW-1:0] idx_q;
	logic found_q;
	logic [IW-1:0] pos_q;
	logic [TW-1:0] total_q;
	logic [30:0] rem_q;
	logic [4:0] bit_q;
	logic [2:0] status_q;
	logic [7:0] winner_q;
	logic ovalid_q;

	logic [IW-1:0] idx;
	logic [ID_BITS-1:0] cid;
	cmd_t take_cmd;
	logic [31:0] trial;
	logic [30:0] rem_next;

	assign idx = idx_q[IW-1:0];
	assign cid = q_cmd.thread_id[ID_BITS-1:0];
	assign q_take = (state_q == S_IDLE) && !ovalid_q;
	assign trial = {rem_q, cmd_q.random_value[bit_q]} - {{(32-TW){1'b0}}, total_q};
	assign rem_next = trial[31] ? {rem_q[29:0], cmd_q.random_value[bit_q]} : trial[30:0];

	always_comb begin
		take_cmd = q_cmd;
		take_cmd.thread_id = 8'(cid);
	end

	assign out_valid = ovalid_q;
	assign out_status = status_q;
	assign out_winner = winner_q;
	assign out_occ = 5'(count_q);

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && cmd_q.action == ACT_INSERT && status_q == ST_OK) begin
			ids_q[idx] <= cmd_q.thread_id[ID_BITS-1:0];
			tix_q[idx] <= cmd_q.ticket_count;
			rdy_q[idx] <= cmd_q.ready_flag;
		end else if (state_q == S_SHIFT && idx_q + 1'b1 < count_q) begin
			ids_q[idx] <= ids_q[IW'(idx_q + 1'b1)];
			tix_q[idx] <= tix_q[IW'(idx_q + 1'b1)];
			rdy_q[idx] <= rdy_q[IW'(idx_q + 1'b1)];
		end else if (state_q == S_DONE && cmd_q.action == ACT_READY && status_q == ST_OK) begin
			rdy_q[pos_q] <= cmd_q.ready_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			cmd_q <= '0;
			pos_q <= '0;
			total_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			status_q <= ST_OK;
			winner_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && q_take) begin
						cmd_q <= take_cmd;
						idx_q <= '0;
						found_q <= 1'b0;
						total_q <= '0;
						pos_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q < count_q && !found_q) begin
						if (cmd_q.action == ACT_DRAW) begin
							if (rdy_q[idx]) begin
								total_q <= total_q + TW'(tix_q[idx]);
							end
						end else if (ids_q[idx] == cmd_q.thread_id[ID_BITS-1:0]) begin
							found_q <= 1'b1;
							pos_q <= idx;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						unique case (cmd_q.action)
							ACT_INSERT: begin
								if (found_q) begin
									status_q <= ST_PRESENT;
								end else if (count_q == CW'(MAX_ENTRIES)) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
								end
								idx_q <= count_q;
								winner_q <= '0;
								state_q <= S_DONE;
							end
							ACT_REMOVE: begin
								winner_q <= '0;
								if (found_q) begin
									status_q <= ST_OK;
									idx_q <= CW'(pos_q);
									state_q <= S_SHIFT;
								end else begin
									status_q <= ST_NOT_FOUND;
									state_q <= S_DONE;
								end
							end
							ACT_READY: begin
								winner_q <= '0;
								status_q <= found_q ? ST_OK : ST_NOT_FOUND;
								state_q <= S_DONE;
							end
							default: begin
								winner_q <= '0;
								if (total_q == '0) begin
									status_q <= ST_NO_TICKETS;
									state_q <= S_DONE;
								end else begin
									rem_q <= '0;
									bit_q <= 5'd30;
									state_q <= S_DIV;
								end
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (idx_q + 1'b1 < count_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					if (bit_q == 5'd0) begin
						idx_q <= '0;
						state_q <= S_WALK;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_WALK: begin
					if (idx_q < count_q) begin
						if (rdy_q[idx]) begin
							if (rem_q < 31'(tix_q[idx])) begin
								winner_q <= 8'(ids_q[idx]);
								status_q <= ST_OK;
								state_q <= S_DONE;
							end else begin
								rem_q <= rem_q - 31'(tix_q[idx]);
							end
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						status_q <= ST_NO_TICKETS;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd_q.action == ACT_INSERT && status_q == ST_OK) begin
						count_q <= count_q + 1'b1;
					end
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== verif/lottery_ticket_scheduler_checker.sv =====
// checker for the lottery ticket scheduler: table predictor and result comparison
module lottery_ticket_scheduler_checker
	import lts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [1:0] action,
	input logic [7:0] thread_id,
	input logic [7:0] ticket_count,
	input logic ready_flag,
	input logic [30:0] random_value,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] status,
	input logic [7:0] winner_id,
	input logic [4:0] occupancy,
	output int fail_count,
	output int pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] winner;
		logic [4:0] occupancy;
	} sched_result_t;

	logic [7:0] tbl_id [MaxEntries];
	logic [7:0] tbl_tickets [MaxEntries];
	logic tbl_ready [MaxEntries];
	int tbl_count;
	sched_result_t expected_results[$];

	function automatic int lookup_slot(logic [7:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic sched_result_t schedule_step(logic [1:0] act, logic [7:0] id,
			logic [7:0] tk, logic rdy, logic [30:0] rnd);
		sched_result_t r;
		int pos;
		int unsigned total;
		int unsigned left;
		r = '0;
		case (act)
			ACT_INSERT: begin
				if (lookup_slot(id) >= 0) r.status = ST_PRESENT;
				else if (tbl_count >= MaxEntries) r.status = ST_FULL;
				else begin
					tbl_id[tbl_count] = id;
					tbl_tickets[tbl_count] = tk;
					tbl_ready[tbl_count] = rdy;
					tbl_count++;
				end
			end
			ACT_REMOVE: begin
				pos = lookup_slot(id);
				if (pos < 0) r.status = ST_NOT_FOUND;
				else begin
					for (int i = pos; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i + 1];
						tbl_tickets[i] = tbl_tickets[i + 1];
						tbl_ready[i] = tbl_ready[i + 1];
					end
					tbl_count--;
				end
			end
			ACT_READY: begin
				pos = lookup_slot(id);
				if (pos < 0) r.status = ST_NOT_FOUND;
				else tbl_ready[pos] = rdy;
			end
			default: begin
				total = 0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_ready[i]) total += tbl_tickets[i];
				r.status = ST_NO_TICKETS;
				if (total != 0) begin
					left = rnd % total;
					for (int i = 0; i < tbl_count; i++) begin
						if (tbl_ready[i] && r.status == ST_NO_TICKETS) begin
							if (left < tbl_tickets[i]) begin
								r.winner = tbl_id[i];
								r.status = ST_OK;
							end else begin
								left -= tbl_tickets[i];
							end
						end
					end
				end
			end
		endcase
		r.occupancy = tbl_count[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t got;
		sched_result_t want;
		if (!arst_n) begin
			tbl_count = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(schedule_step(action, thread_id, ticket_count,
					ready_flag, random_value));
			if (out_valid && !out_stall) begin
				got = '{status, winner_id, occupancy};
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status) begin
						$error("status expected %0d actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.winner != want.winner) begin
						$error("winner_id expected %0d actual %0d", want.winner, got.winner);
						fail_count++;
					end
					if (got.occupancy != want.occupancy) begin
						$error("occupancy expected %0d actual %0d", want.occupancy,
							got.occupancy);
						fail_count++;
					end
				end
			end
		end
		pending_count = expected_results.size();
	end
endmodule

// ===== verif/lottery_ticket_scheduler_core_tb.sv =====
// testbench top for the lottery ticket scheduler: stimulus and verdict
module lottery_ticket_scheduler_core_tb;
	import lts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] action = ACT_INSERT;
	logic [7:0] thread_id = 0;
	logic [7:0] ticket_count = 0;
	logic ready_flag = 0;
	logic [30:0] random_value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [7:0] winner_id;
	logic [4:0] occupancy;
	int fail_count;
	int pending_count;
	int idle_cycles = 0;
	bit calm;
	logic [7:0] id_pool [6];

	always #5 clk = ~clk;

	lottery_ticket_scheduler_core dut (.*);
	lottery_ticket_scheduler_checker checker_i (.*);

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 36);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("lottery_ticket_scheduler_core_tb: done, errors");
			$finish;
		end
	end

	task automatic send_cmd(logic [1:0] act, logic [7:0] id, logic [7:0] tk, logic rdy,
			logic [30:0] rnd);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		thread_id <= id;
		ticket_count <= tk;
		ready_flag <= rdy;
		random_value <= rnd;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [7:0] pick_id();
		return ($urandom_range(99) < 85) ? id_pool[$urandom_range(5)] : 8'($urandom);
	endfunction

	initial begin
		int r;
		calm = 0;
		for (int i = 0; i < 6; i++) id_pool[i] = 8'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table, full table, extremes
		send_cmd(ACT_DRAW, 0, 0, 0, 31'h7fffffff);
		send_cmd(ACT_REMOVE, 8'hff, 0, 0, 0);
		send_cmd(ACT_READY, 0, 0, 1, 0);
		for (int i = 0; i < 16; i++)
			send_cmd(ACT_INSERT, (i == 15) ? 8'hff : 8'(i), (i == 0) ? 8'hff : 8'(i % 3),
				i[0], 0);
		send_cmd(ACT_INSERT, 8'd200, 8'd5, 1, 0);
		send_cmd(ACT_INSERT, 8'hff, 8'd5, 1, 0);
		send_cmd(ACT_DRAW, 0, 0, 0, 31'h7fffffff);
		send_cmd(ACT_DRAW, 0, 0, 0, 0);
		send_cmd(ACT_READY, 8'd0, 0, 0, 0);
		send_cmd(ACT_DRAW, 0, 0, 0, 31'h2aaaaaaa);
		send_cmd(ACT_REMOVE, 8'd5, 0, 0, 0);
		send_cmd(ACT_REMOVE, 8'hff, 0, 0, 0);
		for (int i = 0; i < 16; i++) send_cmd(ACT_REMOVE, 8'(i), 0, 0, 0);
		// random part
		for (int n = 0; n < 1050; n++) begin
			calm = (n >= 400 && n < 550);
			r = $urandom_range(99);
			if (r < 30)
				send_cmd(ACT_INSERT, (r < 24) ? pick_id() : 8'(n), 8'($urandom),
					1'($urandom), 31'($urandom));
			else if (r < 45)
				send_cmd(ACT_REMOVE, pick_id(), 8'($urandom), 1'($urandom), 31'($urandom));
			else if (r < 65)
				send_cmd(ACT_READY, pick_id(), 8'($urandom), 1'($urandom), 31'($urandom));
			else
				send_cmd(ACT_DRAW, 8'($urandom), 8'($urandom), 1'($urandom), 31'($urandom));
			if (n % 150 == 149)
				for (int i = 0; i < 6; i++) id_pool[i] = 8'($urandom);
		end
		in_valid <= 0;
		calm = 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("lottery_ticket_scheduler_core_tb: done, clean");
		else
			$display("lottery_ticket_scheduler_core_tb: done, errors");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/lts_pkg.sv
hw/rtl/lts_front.sv
hw/rtl/lts_back.sv
hw/rtl/lottery_ticket_scheduler_core.sv
verif/lottery_ticket_scheduler_checker.sv
verif/lottery_ticket_scheduler_core_tb.sv
